[rtl/core/tcp_pkg.sv]
package tcp_pkg;

	// fixed-point values: magnitude limited to 2^62-1, signed form one bit wider
	localparam int MAG_W      = 62;
	localparam int VAL_W      = MAG_W + 1;
	localparam int MUL_OP_W   = 32;
	localparam int DIV_STEPS  = 8;

	localparam int STEP_RAD_W = 32;
	localparam int TERM_W     = 5;
	localparam int RADIUS_W   = 11;
	localparam int CENTER_W   = 12;
	localparam int POINT_W    = 14;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [STEP_RAD_W-1:0] STEP_RAD_RST   = 32'd29980;
	localparam logic [TERM_W-1:0]     TERM_COUNT_RST = 5'd10;
	localparam logic [RADIUS_W-1:0]   RADIUS_RST     = 11'd200;
	localparam logic [CENTER_W-1:0]   CENTER_X_RST   = 12'd400;
	localparam logic [CENTER_W-1:0]   CENTER_Y_RST   = 12'd300;

	localparam int POINT_LOW_MAG = 4096;
	localparam int POINT_HIGH    = 8191;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_RAD   = 3'd0,
		REG_TERM_COUNT = 3'd1,
		REG_RADIUS     = 3'd2,
		REG_CENTER_X   = 3'd3,
		REG_CENTER_Y   = 3'd4
	} tcp_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ANG,
		ST_X2,
		ST_SMUL,
		ST_SDIV,
		ST_CMUL,
		ST_CDIV,
		ST_PX,
		ST_PXC,
		ST_PY,
		ST_DONE
	} tcp_state_t;

	typedef struct packed {
		logic start;
		logic frac;
	} tcp_mul_ctl_t;

endpackage

[rtl/core/tcp_if.sv]
interface tcp_in_if #(
	parameter int INDEX_BITS = 20
);
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] step_index;

	modport source (output valid, output step_index, input ready);
	modport sink   (input valid, input step_index, output ready);
endinterface

interface tcp_out_if;
	import tcp_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [POINT_W-1:0] point_x;
	logic signed [POINT_W-1:0] point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

[rtl/core/tcp_mul.sv]
module tcp_mul #(
	parameter int FRAC_BITS = 30
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tcp_pkg::tcp_mul_ctl_t     ctl,
	input  logic [tcp_pkg::MAG_W-1:0] a,
	input  logic [tcp_pkg::MAG_W-1:0] b,
	output logic                      done,
	output logic [tcp_pkg::MAG_W-1:0] res
);
	import tcp_pkg::*;

	localparam int PW   = 2 * MAG_W;
	localparam int PP_W = 2 * MUL_OP_W;
	localparam logic [2:0] PH_END = 3'd4;

	logic [MAG_W-1:0]    a_q;
	logic [MAG_W-1:0]    b_q;
	logic                frac_q;
	logic [2:0]          ph_q;
	logic [PP_W-1:0]     pp_s1;
	logic [1:0]          pp_ph_s1;
	logic                pp_vld_s1;
	logic [PW-1:0]       acc_q;
	logic                done_q;

	logic [MUL_OP_W-1:0] op_a;
	logic [MUL_OP_W-1:0] op_b;
	logic [PW-1:0]       pp_ext;
	logic [PW-1:0]       shifted;

	// partial product order: lo*lo, lo*hi, hi*lo, hi*hi
	always_comb begin
		op_a = ph_q[1] ? MUL_OP_W'(a_q[MAG_W-1:MUL_OP_W]) : a_q[MUL_OP_W-1:0];
		op_b = ph_q[0] ? MUL_OP_W'(b_q[MAG_W-1:MUL_OP_W]) : b_q[MUL_OP_W-1:0];
	end

	always_comb begin
		unique case (pp_ph_s1)
			2'd0: pp_ext = PW'(pp_s1);
			2'd1, 2'd2: pp_ext = PW'(pp_s1) << MUL_OP_W;
			default: pp_ext = PW'(pp_s1) << (2 * MUL_OP_W);
		endcase
	end

	// truncate toward zero on the magnitude, then saturate
	always_comb begin
		shifted = frac_q ? (acc_q >> FRAC_BITS) : acc_q;
		res     = (|shifted[PW-1:MAG_W]) ? {MAG_W{1'b1}} : shifted[MAG_W-1:0];
	end

	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q      <= PH_END;
			pp_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (ctl.start) begin
				ph_q <= 3'd0;
			end else if (ph_q != PH_END) begin
				ph_q <= ph_q + 3'd1;
			end
			pp_vld_s1 <= !ctl.start && (ph_q != PH_END);
			done_q    <= pp_vld_s1 && (pp_ph_s1 == 2'd3);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q    <= a;
			b_q    <= b;
			frac_q <= ctl.frac;
			acc_q  <= '0;
		end else if (pp_vld_s1) begin
			acc_q <= acc_q + pp_ext;
		end
		pp_s1    <= PP_W'(op_a) * PP_W'(op_b);
		pp_ph_s1 <= ph_q[1:0];
	end

endmodule

[rtl/core/tcp_div.sv]
module tcp_div #(
	parameter int DW = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tcp_pkg::MAG_W-1:0] num,
	input  logic [DW-1:0]             den,
	output logic                      done,
	output logic [tcp_pkg::MAG_W-1:0] quo
);
	import tcp_pkg::*;

	localparam int CYC = (MAG_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int QW  = CYC * DIV_STEPS;
	localparam int CW  = $clog2(CYC + 1);

	logic [QW-1:0] work_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [QW-1:0] work_d;
	logic [DW-1:0] rem_d;
	logic [DW:0]   trial;

	// restoring division, one quotient bit per step; quotient bits shift in at the bottom
	always_comb begin
		work_d = work_q;
		rem_d  = rem_q;
		trial  = '0;
		for (int k = 0; k < DIV_STEPS; k++) begin
			trial  = {rem_d, work_d[QW-1]};
			work_d = {work_d[QW-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				trial     = trial - {1'b0, den_q};
				work_d[0] = 1'b1;
			end
			rem_d = trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = work_q[MAG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(CYC - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= QW'(num);
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			work_q <= work_d;
			rem_q  <= rem_d;
		end
	end

endmodule

[rtl/core/taylor_circle_point.sv]
// Point on a circle from a step index, by truncated Taylor series for sine and cosine.
// index_ch carries one step_index per request; point_ch returns one (point_x, point_y)
// per request, in order. The user must write the registers through cfg_wr_en/
// cfg_wr_index/cfg_wr_data only while no request is in flight; the block itself does
// not enforce this. An unknown index is ignored. All arithmetic runs on one shared
// 32x32 multiplier (four partial products per multiply) and one shared divider for
// the term constants (8 quotient bits a cycle while busy). The term count resets to
// ten. A new request is taken only after the previous result has been loaded into
// the output register, so the throughput is set by the term loop on the multiplier
// and divider.
// index_ch.ready is high only while the sequencer is idle. The result sits in an
// output register: a stalled receiver does not block the next request, but a
// finished point waits until the previous one has been taken.
// Reset (arst_n low) returns the sequencer to idle, drops any pending result and
// loads the register defaults.
module taylor_circle_point #(
	parameter int INDEX_BITS = 20,
	parameter int FRAC_BITS  = 30,
	parameter int MAX_TERMS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [tcp_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
	input  logic [tcp_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	tcp_in_if.sink                         index_ch,
	tcp_out_if.source                      point_ch
);
	import tcp_pkg::*;

	localparam int NW    = $clog2(MAX_TERMS + 1);
	localparam int TW    = NW + 1;
	localparam int DMAX  = 2 * (MAX_TERMS - 1) * (2 * MAX_TERMS - 1);
	localparam int DW    = $clog2(DMAX + 1);
	localparam int XW    = 2 * STEP_RAD_W;
	localparam int SH_UP = (FRAC_BITS > STEP_RAD_W) ? FRAC_BITS - STEP_RAD_W : 0;
	localparam int SH_DN = (FRAC_BITS < STEP_RAD_W) ? STEP_RAD_W - FRAC_BITS : 0;
	localparam logic signed [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS;

	tcp_state_t state_q, state_d;
	logic       launch_q;

	logic [STEP_RAD_W-1:0] step_rad_q;
	logic [TERM_W-1:0]     term_count_q;
	logic [RADIUS_W-1:0]   radius_q;
	logic [CENTER_W-1:0]   center_x_q;
	logic [CENTER_W-1:0]   center_y_q;

	logic [INDEX_BITS-1:0]     idx_q;
	logic [NW-1:0]             cnt_q;
	logic [NW-1:0]             n_q;
	logic [MAG_W-1:0]          x_q;
	logic [MAG_W-1:0]          x2_q;
	logic signed [VAL_W-1:0]   st_q, ss_q, ct_q, cs_q, v_q;
	logic [POINT_W-1:0]        px_q;
	logic [POINT_W-1:0]        point_x_q;
	logic [POINT_W-1:0]        point_y_q;
	logic                      out_valid_q;

	tcp_mul_ctl_t     mul_ctl;
	logic [MAG_W-1:0] mul_a, mul_b, mul_res;
	logic             mul_done;
	logic             div_start, div_done;
	logic [DW-1:0]    div_den;
	logic [MAG_W-1:0] div_quo;

	logic                    out_load;
	logic                    index_accept;
	logic                    last_term;
	logic [NW-1:0]           cnt_in;
	logic [TW-1:0]           two_n;
	logic [2*TW-1:0]         ds_full, dc_full;
	logic [DW-1:0]           ds, dc;
	logic [XW-1:0]           x_wide;
	logic [MAG_W-1:0]        x_scaled;
	logic signed [VAL_W-1:0] cx_fix, cy_fix;

	function automatic logic [MAG_W-1:0] mag_of(input logic signed [VAL_W-1:0] v);
		logic signed [VAL_W-1:0] t;
		t = v[VAL_W-1] ? -v : v;
		return t[MAG_W-1:0];
	endfunction

	// a +/- m, clamped to the magnitude limit
	function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] a,
	                                                    input logic [MAG_W-1:0] m,
	                                                    input logic neg);
		logic signed [VAL_W:0] s;
		logic signed [VAL_W:0] lim;
		lim = $signed({2'b00, {MAG_W{1'b1}}});
		s   = neg ? ($signed({a[VAL_W-1], a}) - $signed({2'b00, m}))
		          : ($signed({a[VAL_W-1], a}) + $signed({2'b00, m}));
		if (s > lim) begin
			s = lim;
		end else if (s < -lim) begin
			s = -lim;
		end
		return VAL_W'(s);
	endfunction

	// integer part toward zero, clamped to the pixel range
	function automatic logic [POINT_W-1:0] to_pixel(input logic signed [VAL_W-1:0] v);
		logic [MAG_W-1:0]   ip;
		logic [POINT_W-1:0] p;
		ip = mag_of(v) >> FRAC_BITS;
		if (v[VAL_W-1]) begin
			if (ip > MAG_W'(POINT_LOW_MAG)) begin
				p = POINT_W'(0) - POINT_W'(POINT_LOW_MAG);
			end else begin
				p = POINT_W'(0) - POINT_W'(ip);
			end
		end else if (ip > MAG_W'(POINT_HIGH)) begin
			p = POINT_W'(POINT_HIGH);
		end else begin
			p = POINT_W'(ip);
		end
		return p;
	endfunction

	assign index_accept = index_ch.valid && index_ch.ready;
	assign last_term    = (NW'(n_q + NW'(1)) == cnt_q);

	assign two_n   = {n_q, 1'b0};
	assign ds_full = (2*TW)'(two_n) * (2*TW)'(two_n + TW'(1));
	assign dc_full = (2*TW)'(two_n - TW'(1)) * (2*TW)'(two_n);
	assign ds      = DW'(ds_full);
	assign dc      = DW'(dc_full);

	assign cx_fix = $signed(VAL_W'(center_x_q) << FRAC_BITS);
	assign cy_fix = $signed(VAL_W'(center_y_q) << FRAC_BITS);

	// rescale the Q30.32 angle to the internal fraction width
	always_comb begin
		x_wide   = (XW'(mul_res) << SH_UP) >> SH_DN;
		x_scaled = (|x_wide[XW-1:MAG_W]) ? {MAG_W{1'b1}} : x_wide[MAG_W-1:0];
	end

	always_comb begin
		if (term_count_q == '0) begin
			cnt_in = NW'(1);
		end else if (int'(term_count_q) > MAX_TERMS) begin
			cnt_in = NW'(MAX_TERMS);
		end else begin
			cnt_in = NW'(term_count_q);
		end
	end

	always_comb begin
		state_d        = state_q;
		mul_ctl        = '0;
		mul_a          = '0;
		mul_b          = '0;
		div_start      = 1'b0;
		div_den        = '0;
		out_load       = 1'b0;
		index_ch.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				index_ch.ready = 1'b1;
				if (index_ch.valid) begin
					state_d = ST_ANG;
				end
			end
			ST_ANG: begin
				mul_ctl.start = launch_q;
				mul_a         = MAG_W'(idx_q);
				mul_b         = MAG_W'(step_rad_q);
				if (mul_done) begin
					state_d = ST_X2;
				end
			end
			ST_X2: begin
				mul_ctl.start = launch_q;
				mul_ctl.frac  = 1'b1;
				mul_a         = x_q;
				mul_b         = x_q;
				if (mul_done) begin
					state_d = (cnt_q == NW'(1)) ? ST_PX : ST_SMUL;
				end
			end
			ST_SMUL: begin
				mul_ctl.start = launch_q;
				mul_ctl.frac  = 1'b1;
				mul_a         = mag_of(st_q);
				mul_b         = x2_q;
				if (mul_done) begin
					state_d = ST_SDIV;
				end
			end
			ST_SDIV: begin
				div_start = launch_q;
				div_den   = ds;
				if (div_done) begin
					state_d = ST_CMUL;
				end
			end
			ST_CMUL: begin
				mul_ctl.start = launch_q;
				mul_ctl.frac  = 1'b1;
				mul_a         = mag_of(ct_q);
				mul_b         = x2_q;
				if (mul_done) begin
					state_d = ST_CDIV;
				end
			end
			ST_CDIV: begin
				div_start = launch_q;
				div_den   = dc;
				if (div_done) begin
					state_d = last_term ? ST_PX : ST_SMUL;
				end
			end
			ST_PX: begin
				mul_ctl.start = launch_q;
				mul_a         = mag_of(cs_q);
				mul_b         = MAG_W'(radius_q);
				if (mul_done) begin
					state_d = ST_PXC;
				end
			end
			ST_PXC: begin
				state_d = ST_PY;
			end
			ST_PY: begin
				mul_ctl.start = launch_q;
				mul_a         = mag_of(ss_q);
				mul_b         = MAG_W'(radius_q);
				if (mul_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold until the previous point has left the output register
				if (!out_valid_q || point_ch.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			launch_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= (state_d != state_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_rad_q   <= STEP_RAD_RST;
			term_count_q <= TERM_COUNT_RST;
			radius_q     <= RADIUS_RST;
			center_x_q   <= CENTER_X_RST;
			center_y_q   <= CENTER_Y_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_wr_index)
				REG_STEP_RAD:   step_rad_q   <= cfg_wr_data[STEP_RAD_W-1:0];
				REG_TERM_COUNT: term_count_q <= cfg_wr_data[TERM_W-1:0];
				REG_RADIUS:     radius_q     <= cfg_wr_data[RADIUS_W-1:0];
				REG_CENTER_X:   center_x_q   <= cfg_wr_data[CENTER_W-1:0];
				REG_CENTER_Y:   center_y_q   <= cfg_wr_data[CENTER_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (point_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (index_accept) begin
			idx_q <= index_ch.step_index;
			cnt_q <= cnt_in;
			n_q   <= NW'(1);
		end
		if (state_q == ST_ANG && mul_done) begin
			x_q  <= x_scaled;
			st_q <= $signed({1'b0, x_scaled});
			ss_q <= $signed({1'b0, x_scaled});
			ct_q <= ONE;
			cs_q <= ONE;
		end
		if (state_q == ST_X2 && mul_done) begin
			x2_q <= mul_res;
		end
		// each new term flips the sign of the previous one
		if (state_q == ST_SDIV && div_done) begin
			st_q <= st_q[VAL_W-1] ? $signed({1'b0, div_quo}) : -$signed({1'b0, div_quo});
			ss_q <= sat_add(ss_q, div_quo, !st_q[VAL_W-1]);
		end
		if (state_q == ST_CDIV && div_done) begin
			ct_q <= ct_q[VAL_W-1] ? $signed({1'b0, div_quo}) : -$signed({1'b0, div_quo});
			cs_q <= sat_add(cs_q, div_quo, !ct_q[VAL_W-1]);
			if (!last_term) begin
				n_q <= NW'(n_q + NW'(1));
			end
		end
		if (state_q == ST_PX && mul_done) begin
			v_q <= sat_add(cx_fix, mul_res, cs_q[VAL_W-1]);
		end
		if (state_q == ST_PXC) begin
			px_q <= to_pixel(v_q);
		end
		if (state_q == ST_PY && mul_done) begin
			v_q <= sat_add(cy_fix, mul_res, ss_q[VAL_W-1]);
		end
		if (out_load) begin
			point_x_q <= px_q;
			point_y_q <= to_pixel(v_q);
		end
	end

	assign point_ch.valid   = out_valid_q;
	assign point_ch.point_x = $signed(point_x_q);
	assign point_ch.point_y = $signed(point_y_q);

	tcp_mul #(
		.FRAC_BITS (FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res)
	);

	tcp_div #(
		.DW (DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mul_res),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

endmodule
